FILE: hdl/selective_repeat_receive_window_top_macros.svh
// assertion macros for the receive window block
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define SRW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define SRW_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);
`else
`define SRW_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define SRW_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif

`endif

FILE: hdl/srw_pkg.sv
// shared constants, types and helpers of the receive window
package srw_pkg;

  localparam int SLOTS         = 16;
  localparam int SEGMENT_BYTES = 1000;

  localparam int OFS_W  = 24;
  localparam int SIZE_W = 10;
  localparam int CMD_W  = 2;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int SUM_W  = CNT_W + 1;

  localparam logic [CMD_W-1:0] CMD_START  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ARRIVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIST   = 2'd2;

  localparam logic KIND_REL  = 1'b0;
  localparam logic KIND_LIST = 1'b1;

  typedef struct packed {
    logic [OFS_W-1:0]  offset;
    logic [SIZE_W-1:0] size;
    logic              ready;
  } slot_t;

  typedef struct packed {
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t            wr_data;
  } mem_req_t;

  // circular slot address: base below SLOTS, step up to SLOTS
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] step);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(step);
    if (sum >= SUM_W'(SLOTS)) begin
      sum = sum - SUM_W'(SLOTS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

FILE: hdl/srw_if.sv
// request channels of the receive window
interface srw_in_if;
  logic                          valid;
  logic                          ready;
  logic [srw_pkg::CMD_W-1:0]     command;
  logic [srw_pkg::OFS_W-1:0]     seg_start;

  modport source (output valid, command, seg_start, input ready);
  modport sink (input valid, command, seg_start, output ready);
endinterface

interface srw_out_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [srw_pkg::OFS_W-1:0]     seg_offset;
  logic [srw_pkg::SIZE_W-1:0]    seg_size;
  logic                          seg_rcvd;
  logic                          last;
  logic                          done_res;

  modport source (output valid, kind, seg_offset, seg_size, seg_rcvd, last, done_res,
                  input ready);
  modport sink (input valid, kind, seg_offset, seg_size, seg_rcvd, last, done_res,
                output ready);
endinterface

FILE: hdl/srw_slot_mem.sv
// slot memory: one write port, one registered read port, per-entry valid bits
module srw_slot_mem (
  input  logic              clk,
  input  logic              rst,
  input  srw_pkg::mem_req_t req,
  output srw_pkg::slot_t    rdata
);

  srw_pkg::slot_t               mem [srw_pkg::SLOTS];
  logic [srw_pkg::SLOTS-1:0]    vld;
  srw_pkg::slot_t               rd_q;
  logic                         rd_vld;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld <= vld[req.rd_addr];
      end
    end
  end

  // never-written entries read as the cleared slot
  assign rdata = rd_vld ? rd_q : '0;

endmodule

FILE: hdl/srw_seq.sv
// sequencer: scan, release, list and refill passes over the slot memory
module srw_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [srw_pkg::OFS_W-1:0] total_bytes,
  srw_in_if.sink                    in_ch,
  srw_out_if.source                 out_ch,
  output srw_pkg::mem_req_t         req,
  input  srw_pkg::slot_t            rdata
);

  typedef enum logic [4:0] {
    ST_IDLE    = 5'b00001,
    ST_SCAN    = 5'b00010,
    ST_EMIT_RD = 5'b00100,
    ST_EMIT_LD = 5'b01000,
    ST_FILL    = 5'b10000
  } state_t;

  state_t                      state;
  logic [srw_pkg::IDX_W-1:0]   head;
  logic [srw_pkg::OFS_W-1:0]   remaining;
  logic [srw_pkg::OFS_W-1:0]   next_off;
  logic [srw_pkg::OFS_W-1:0]   seg_start_q;

  logic [srw_pkg::CNT_W-1:0]   rd_i;
  logic                        pend;
  logic [srw_pkg::IDX_W-1:0]   pend_i;
  logic                        found;
  logic                        prefix;
  logic                        tail;
  logic [srw_pkg::CNT_W-1:0]   rel_cnt;

  logic [srw_pkg::IDX_W-1:0]   emit_i;
  logic [srw_pkg::CNT_W-1:0]   emit_n;
  logic                        emit_kind;
  logic                        emit_done;
  logic                        after_fill;
  logic [srw_pkg::IDX_W-1:0]   fill_i;
  logic [srw_pkg::CNT_W-1:0]   fill_n;

  logic                        out_valid;
  logic                        out_kind;
  logic [srw_pkg::OFS_W-1:0]   out_offset;
  logic [srw_pkg::SIZE_W-1:0]  out_size;
  logic                        out_rdy;
  logic                        out_last;
  logic                        out_done;

  logic                        in_acc;
  logic                        out_free;
  logic                        out_load;
  logic                        rd_issue;
  logic                        scan_hit;
  logic                        scan_rel;
  logic                        scan_tail;
  logic                        scan_end;
  logic [srw_pkg::CNT_W-1:0]   scan_cnt;
  logic                        emit_last;
  logic                        fill_last;
  logic                        fill_short;
  srw_pkg::slot_t              fill_slot;
  srw_pkg::slot_t              mark_slot;

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;
  assign out_load    = (state == ST_EMIT_LD) && out_free;

  assign rd_issue = (state == ST_SCAN) && (rd_i < srw_pkg::CNT_W'(srw_pkg::SLOTS));

  // first matching slot is marked, release runs on the marked view
  assign scan_hit  = !found && (rdata.offset == seg_start_q);
  assign scan_rel  = prefix && (rdata.ready || scan_hit) && (rdata.size != '0);
  assign scan_tail = tail || (!scan_rel && (rdata.size != '0));
  assign scan_cnt  = rel_cnt + srw_pkg::CNT_W'(scan_rel);
  assign scan_end  = pend && (pend_i == srw_pkg::IDX_W'(srw_pkg::SLOTS - 1));

  assign emit_last = (srw_pkg::CNT_W'(emit_i) == emit_n - 1'b1);
  assign fill_last = (srw_pkg::CNT_W'(fill_i) == fill_n - 1'b1);

  assign fill_short       = remaining < srw_pkg::OFS_W'(srw_pkg::SEGMENT_BYTES);
  assign fill_slot.offset = next_off;
  assign fill_slot.size   = fill_short ? remaining[srw_pkg::SIZE_W-1:0]
                                       : srw_pkg::SIZE_W'(srw_pkg::SEGMENT_BYTES);
  assign fill_slot.ready  = 1'b0;

  assign mark_slot.offset = rdata.offset;
  assign mark_slot.size   = rdata.size;
  assign mark_slot.ready  = 1'b1;

  always_comb begin
    req = '0;
    unique case (state)
      ST_SCAN: begin
        req.rd_en   = rd_issue;
        req.rd_addr = srw_pkg::wrap_add(head, rd_i);
        req.wr_en   = pend && scan_hit;
        req.wr_addr = srw_pkg::wrap_add(head, srw_pkg::CNT_W'(pend_i));
        req.wr_data = mark_slot;
      end
      ST_EMIT_RD: begin
        req.rd_en   = 1'b1;
        req.rd_addr = srw_pkg::wrap_add(head, srw_pkg::CNT_W'(emit_i));
      end
      ST_FILL: begin
        req.wr_en   = 1'b1;
        req.wr_addr = srw_pkg::wrap_add(head, srw_pkg::CNT_W'(fill_i));
        req.wr_data = fill_slot;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      remaining <= '0;
      next_off  <= '0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            unique case (in_ch.command)
              srw_pkg::CMD_START: begin
                remaining <= total_bytes;
                next_off  <= '0;
                head      <= '0;
                fill_i    <= '0;
                fill_n    <= srw_pkg::CNT_W'(srw_pkg::SLOTS);
                state     <= ST_FILL;
              end
              srw_pkg::CMD_ARRIVE: begin
                seg_start_q <= in_ch.seg_start;
                rd_i        <= '0;
                pend        <= 1'b0;
                found       <= 1'b0;
                prefix      <= 1'b1;
                tail        <= 1'b0;
                rel_cnt     <= '0;
                state       <= ST_SCAN;
              end
              srw_pkg::CMD_LIST: begin
                emit_i     <= '0;
                emit_n     <= srw_pkg::CNT_W'(srw_pkg::SLOTS);
                emit_kind  <= srw_pkg::KIND_LIST;
                emit_done  <= 1'b0;
                after_fill <= 1'b0;
                state      <= ST_EMIT_RD;
              end
              default: begin
                state <= ST_IDLE;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (rd_issue) begin
            rd_i <= rd_i + 1'b1;
          end
          pend   <= rd_issue;
          pend_i <= rd_i[srw_pkg::IDX_W-1:0];
          if (pend) begin
            if (scan_hit) begin
              found <= 1'b1;
            end
            if (!scan_rel) begin
              prefix <= 1'b0;
            end
            rel_cnt <= scan_cnt;
            tail    <= scan_tail;
          end
          if (scan_end) begin
            if (scan_cnt == '0) begin
              state <= ST_IDLE;
            end else begin
              // refill of released slots is empty exactly when nothing remains
              emit_i     <= '0;
              emit_n     <= scan_cnt;
              emit_kind  <= srw_pkg::KIND_REL;
              emit_done  <= (remaining == '0) && !scan_tail;
              after_fill <= 1'b1;
              fill_i     <= '0;
              fill_n     <= scan_cnt;
              state      <= ST_EMIT_RD;
            end
          end
        end
        ST_EMIT_RD: begin
          state <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          if (out_free) begin
            out_kind   <= emit_kind;
            out_offset <= rdata.offset;
            out_size   <= rdata.size;
            out_rdy    <= rdata.ready;
            out_last   <= emit_last;
            out_done   <= emit_done;
            if (emit_last) begin
              state <= after_fill ? ST_FILL : ST_IDLE;
            end else begin
              emit_i <= emit_i + 1'b1;
              state  <= ST_EMIT_RD;
            end
          end
        end
        ST_FILL: begin
          if (fill_short) begin
            remaining <= '0;
          end else begin
            remaining <= remaining - srw_pkg::OFS_W'(srw_pkg::SEGMENT_BYTES);
            next_off  <= next_off + srw_pkg::OFS_W'(srw_pkg::SEGMENT_BYTES);
          end
          if (fill_last) begin
            // window moves past the released slots
            head  <= srw_pkg::wrap_add(head, fill_n);
            state <= ST_IDLE;
          end else begin
            fill_i <= fill_i + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.kind       = out_kind;
  assign out_ch.seg_offset = out_offset;
  assign out_ch.seg_size   = out_size;
  assign out_ch.seg_rcvd   = out_rdy;
  assign out_ch.last       = out_last;
  assign out_ch.done_res   = out_done;

endmodule

FILE: hdl/selective_repeat_receive_window_top.sv
// top level of the selective-repeat receive window
//
// in_ch takes one command per request: start builds the window from total_bytes,
// arrive marks the slot holding seg_start and releases the ready front slots,
// list reports every slot. out_ch carries a result per released or listed slot,
// last set on the final result of a command. The user must write total_bytes
// through cfg_wr_en and cfg_wr_data while the block is idle (it is not enforced).
// The window sits in a slot memory with one read and one write port, used as a
// ring with a moving head. Steps, per command, with SLOTS slots:
//   start: one slot written per cycle, no result
//   arrive: a scan of all slots, then a read and a load per released slot,
//     then one refill write per released slot
//   list: a read and a load per slot
// The single read port serializes the slot reads. The last result waits in the
// output register while the next command is taken; a stalled sink holds earlier
// results and the sequencer waits for it. Reset empties the window (all slots
// read as zero offset and size) and clears total_bytes.
`include "selective_repeat_receive_window_top_macros.svh"

module selective_repeat_receive_window_top (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [srw_pkg::OFS_W-1:0] cfg_wr_data,
  srw_in_if.sink                    in_ch,
  srw_out_if.source                 out_ch
);

  logic [srw_pkg::OFS_W-1:0] total_bytes;
  srw_pkg::mem_req_t         req;
  srw_pkg::slot_t            rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      total_bytes <= '0;
    end else if (cfg_wr_en) begin
      total_bytes <= cfg_wr_data;
    end
  end

  srw_slot_mem u_mem (
    .clk   (clk),
    .rst   (rst),
    .req   (req),
    .rdata (rdata)
  );

  srw_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .total_bytes (total_bytes),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .req         (req),
    .rdata       (rdata)
  );

  // the mark write-back never lands on the slot being read
  `SRW_ASSERT_NEVER(a_no_rw_clash, clk, rst, req.rd_en && req.wr_en && (req.rd_addr == req.wr_addr), "read and write hit the same slot")
  `SRW_ASSERT_IMPLIES(a_idle_quiet, clk, rst, in_ch.ready, !req.rd_en && !req.wr_en, "memory busy while taking a command")
  `SRW_ASSERT_IMPLIES(a_rel_ready, clk, rst, out_ch.valid && (out_ch.kind == srw_pkg::KIND_REL), out_ch.seg_rcvd && (out_ch.seg_size != '0), "released slot not ready or empty")
  `SRW_ASSERT_IMPLIES(a_list_not_done, clk, rst, out_ch.valid && (out_ch.kind == srw_pkg::KIND_LIST), !out_ch.done_res, "list result flagged done")

endmodule

FILE: bench/testbench.sv
// testbench of the selective-repeat receive window: directed table, then random transfers
`timescale 1ns / 1ps

module testbench;

  localparam logic [srw_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RAND_ITEMS    = 250;
  localparam int SETTLE_CYCLES = 64;
  localparam int LIMIT_CYCLES  = 400000;

  typedef struct packed {
    logic                       kind;
    logic [srw_pkg::OFS_W-1:0]  seg_offset;
    logic [srw_pkg::SIZE_W-1:0] seg_size;
    logic                       seg_rcvd;
    logic                       last;
    logic                       done_res;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_op_t;

  typedef struct packed {
    row_op_t                   op;
    logic [srw_pkg::CMD_W-1:0] cmd;
    logic [srw_pkg::OFS_W-1:0] value;
    logic                      typed;
    logic [4:0]                n_exp;
    result_t                   tmpl;
  } row_t;

  localparam int DIR_ROWS = 24;
  localparam row_t DIRECTED [DIR_ROWS] = '{
    // straight after reset the window is all zero
    '{ROW_ITEM, srw_pkg::CMD_LIST,   24'd0,      1'b1, 5'd16,
      '{srw_pkg::KIND_LIST, 24'd0, 10'd0, 1'b0, 1'b0, 1'b0}},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd0,      1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_LIST,   24'd0,      1'b0, 5'd0, '0},
    '{ROW_ITEM, CMD_UNUSED,          24'hFFFFFF, 1'b1, 5'd0, '0},
    '{ROW_CFG,  srw_pkg::CMD_START,  24'd0,      1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_START,  24'd0,      1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd0,      1'b1, 5'd0, '0},
    // two full pieces and a remainder, the rest of the slots share its offset
    '{ROW_CFG,  srw_pkg::CMD_START,  24'd2500,   1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_START,  24'd0,      1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_LIST,   24'd0,      1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd1000,   1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd1000,   1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd0,      1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'hFFFFFF, 1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd2000,   1'b1, 5'd1,
      '{srw_pkg::KIND_REL, 24'd2000, 10'd500, 1'b1, 1'b0, 1'b1}},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd2000,   1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_LIST,   24'd0,      1'b0, 5'd0, '0},
    '{ROW_CFG,  srw_pkg::CMD_START,  24'hFFFFFF, 1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_START,  24'hFFFFFF, 1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd0,      1'b1, 5'd1,
      '{srw_pkg::KIND_REL, 24'd0, 10'd1000, 1'b1, 1'b0, 1'b0}},
    '{ROW_ITEM, srw_pkg::CMD_LIST,   24'd0,      1'b0, 5'd0, '0},
    '{ROW_CFG,  srw_pkg::CMD_START,  24'd1,      1'b0, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_START,  24'd0,      1'b1, 5'd0, '0},
    '{ROW_ITEM, srw_pkg::CMD_ARRIVE, 24'd0,      1'b1, 5'd1,
      '{srw_pkg::KIND_REL, 24'd0, 10'd1, 1'b1, 1'b0, 1'b1}}
  };

  localparam logic [srw_pkg::OFS_W-1:0] EDGE_TOTALS [8] = '{
    24'd0, 24'd1, 24'd999, 24'd1000, 24'd1001, 24'd16000, 24'd16001, 24'hFFFFFF
  };

  logic clk;
  logic rst;
  logic cfg_wr_en;
  logic [srw_pkg::OFS_W-1:0] cfg_wr_data;
  logic take_ready = 1'b0;
  bit calm = 1'b0;

  srw_in_if  in_ch ();
  srw_out_if out_ch ();

  assign out_ch.ready = take_ready;

  selective_repeat_receive_window_top DUT (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  // window as the block should hold it
  logic [srw_pkg::OFS_W-1:0]  slot_ofs [srw_pkg::SLOTS];
  logic [srw_pkg::SIZE_W-1:0] slot_sz  [srw_pkg::SLOTS];
  logic                       slot_rdy [srw_pkg::SLOTS];
  logic [srw_pkg::OFS_W-1:0]  rem_bytes;
  logic [srw_pkg::OFS_W-1:0]  next_ofs;
  logic [srw_pkg::OFS_W-1:0]  cfg_total;

  result_t step_results [$];
  result_t pending_results [$];

  int n_errors = 0;
  int n_items = 0;
  int n_totals = 0;
  int n_released = 0;
  int n_listed = 0;
  int n_whole = 0;
  int cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void refill_from(input int first);
    for (int i = first; i < srw_pkg::SLOTS; i++) begin
      slot_rdy[i] = 1'b0;
      slot_ofs[i] = next_ofs;
      if (rem_bytes < srw_pkg::SEGMENT_BYTES) begin
        slot_sz[i] = rem_bytes[srw_pkg::SIZE_W-1:0];
        rem_bytes = '0;
      end else begin
        slot_sz[i] = srw_pkg::SIZE_W'(srw_pkg::SEGMENT_BYTES);
        rem_bytes = rem_bytes - srw_pkg::OFS_W'(srw_pkg::SEGMENT_BYTES);
        next_ofs = next_ofs + srw_pkg::OFS_W'(srw_pkg::SEGMENT_BYTES);
      end
    end
  endfunction

  function automatic bit transfer_done();
    bit fin;
    fin = (rem_bytes == 0);
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      if (slot_sz[i] != 0) fin = 1'b0;
    end
    return fin;
  endfunction

  // advance the window by one request, leaving its results in step_results
  function automatic void window_step(input logic [srw_pkg::CMD_W-1:0] cmd,
                                      input logic [srw_pkg::OFS_W-1:0] start);
    bit hit;
    bit fin;
    int n;
    step_results.delete();
    case (cmd)
      srw_pkg::CMD_START: begin
        rem_bytes = cfg_total;
        next_ofs = '0;
        refill_from(0);
      end
      srw_pkg::CMD_LIST: begin
        for (int i = 0; i < srw_pkg::SLOTS; i++) begin
          step_results.push_back('{srw_pkg::KIND_LIST, slot_ofs[i], slot_sz[i],
                                   slot_rdy[i], i == srw_pkg::SLOTS - 1, 1'b0});
        end
      end
      srw_pkg::CMD_ARRIVE: begin
        hit = 1'b0;
        for (int i = 0; i < srw_pkg::SLOTS; i++) begin
          if (!hit && slot_ofs[i] == start) begin
            slot_rdy[i] = 1'b1;
            hit = 1'b1;
          end
        end
        n = 0;
        while (n < srw_pkg::SLOTS && slot_rdy[n] && slot_sz[n] != 0) begin
          step_results.push_back('{srw_pkg::KIND_REL, slot_ofs[n], slot_sz[n],
                                   1'b1, 1'b0, 1'b0});
          n++;
        end
        if (n > 0) begin
          for (int i = 0; i < srw_pkg::SLOTS - n; i++) begin
            slot_ofs[i] = slot_ofs[i + n];
            slot_sz[i]  = slot_sz[i + n];
            slot_rdy[i] = slot_rdy[i + n];
          end
          refill_from(srw_pkg::SLOTS - n);
          fin = transfer_done();
          foreach (step_results[j]) step_results[j].done_res = fin;
          step_results[n - 1].last = 1'b1;
          if (n == srw_pkg::SLOTS) n_whole++;
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_request(input logic [srw_pkg::CMD_W-1:0] cmd,
                              input logic [srw_pkg::OFS_W-1:0] start);
    if (!calm && $urandom_range(0, 99) < 21) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.command <= cmd;
    in_ch.seg_start <= start;
    do @(posedge clk); while (!in_ch.ready);
    window_step(cmd, start);
    if (cmd != CMD_UNUSED) n_items++;
  endtask

  task automatic write_total(input logic [srw_pkg::OFS_W-1:0] value);
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    // a start or a silent arrival may still be busy with the window
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cfg_total = value;
    n_totals++;
  endtask

  initial begin
    result_t r;
    logic [srw_pkg::CMD_W-1:0] cmd;
    logic [srw_pkg::OFS_W-1:0] start;
    logic [srw_pkg::OFS_W-1:0] total;
    int base;
    int budget;
    int roll;
    int front;
    int back;
    int first_rdy;
    bit reverse;

    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    in_ch.valid <= 1'b0;
    in_ch.command <= srw_pkg::CMD_LIST;
    in_ch.seg_start <= '0;
    for (int i = 0; i < srw_pkg::SLOTS; i++) begin
      slot_ofs[i] = '0;
      slot_sz[i] = '0;
      slot_rdy[i] = 1'b0;
    end
    rem_bytes = '0;
    next_ofs = '0;
    cfg_total = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[k]) begin
      if (DIRECTED[k].op == ROW_CFG) begin
        write_total(DIRECTED[k].value);
      end else begin
        send_request(DIRECTED[k].cmd, DIRECTED[k].value);
        if (DIRECTED[k].typed) begin
          for (int j = 0; j < DIRECTED[k].n_exp; j++) begin
            r = DIRECTED[k].tmpl;
            r.last = (j == DIRECTED[k].n_exp - 1);
            pending_results.push_back(r);
          end
        end else begin
          foreach (step_results[j]) pending_results.push_back(step_results[j]);
        end
      end
    end

    // random transfers: mostly requests for slots still missing, some noise
    base = n_items;
    while (n_items - base < RAND_ITEMS) begin
      reverse = ($urandom_range(0, 3) == 0);
      if (reverse) total = srw_pkg::OFS_W'($urandom_range(17000, 40000));
      else if ($urandom_range(0, 9) == 0) total = EDGE_TOTALS[$urandom_range(0, 7)];
      else total = srw_pkg::OFS_W'($urandom_range(0, 30000));
      write_total(total);
      send_request(srw_pkg::CMD_START, srw_pkg::OFS_W'($urandom));
      budget = $urandom_range(20, 60);
      while (budget > 0 && !transfer_done() && n_items - base < RAND_ITEMS) begin
        calm = (n_items - base >= 120 && n_items - base < 170);
        front = -1;
        back = -1;
        first_rdy = -1;
        for (int i = 0; i < srw_pkg::SLOTS; i++) begin
          if (slot_sz[i] != 0 && !slot_rdy[i]) begin
            if (front < 0) front = i;
            back = i;
          end
          if (slot_rdy[i] && first_rdy < 0) first_rdy = i;
        end
        roll = $urandom_range(0, 99);
        cmd = srw_pkg::CMD_ARRIVE;
        start = srw_pkg::OFS_W'($urandom);
        if (roll < 8) cmd = srw_pkg::CMD_LIST;
        else if (roll < 10) cmd = CMD_UNUSED;
        else if (roll < 12) cmd = srw_pkg::CMD_START;
        else if (roll < 20) ;  // offset outside the window, almost surely
        else if (roll < 26) start = slot_ofs[first_rdy >= 0 ? first_rdy : 0];
        else if (front < 0) start = slot_ofs[0];
        else if (reverse) start = slot_ofs[back];
        else if ($urandom_range(0, 1) == 0) start = slot_ofs[front];
        else start = slot_ofs[$urandom_range(front, back)];
        send_request(cmd, start);
        foreach (step_results[j]) pending_results.push_back(step_results[j]);
        budget--;
      end
    end
    calm = 1'b0;

    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests over %0d transfer lengths; %0d segments released, %0d slots listed",
             n_items, n_totals, n_released, n_listed);
    $display("%0d arrivals released the whole window, %0d mismatches", n_whole, n_errors);
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  always @(posedge clk) begin : watch_results
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: kind %0d offset %0d size %0d",
               out_ch.kind, out_ch.seg_offset, out_ch.seg_size);
        n_errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
          n_errors++;
        end
        if (out_ch.seg_offset !== want.seg_offset) begin
          $error("seg_offset: expected %0d, got %0d", want.seg_offset, out_ch.seg_offset);
          n_errors++;
        end
        if (out_ch.seg_size !== want.seg_size) begin
          $error("seg_size: expected %0d, got %0d", want.seg_size, out_ch.seg_size);
          n_errors++;
        end
        if (out_ch.seg_rcvd !== want.seg_rcvd) begin
          $error("seg_rcvd: expected %0d, got %0d", want.seg_rcvd, out_ch.seg_rcvd);
          n_errors++;
        end
        if (out_ch.last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_ch.last);
          n_errors++;
        end
        if (out_ch.done_res !== want.done_res) begin
          $error("done_res: expected %0d, got %0d", want.done_res, out_ch.done_res);
          n_errors++;
        end
        if (want.kind == srw_pkg::KIND_REL) n_released++;
        else n_listed++;
      end
    end
    take_ready <= calm || ($urandom_range(0, 99) >= 21);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("run stopped after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
